// ===== sv/fro_pkg.sv =====
// fro_pkg: shared types and constants of the first-come-first-served rank order block
// depends on nothing; imported by fro_out_stage and fcfs_rank_order_top
package fro_pkg;

    localparam int JOB_CAPACITY = 64;            // jobs kept per batch, 2..64
    localparam int IDX_W        = 6;             // job index width
    localparam int CNT_W        = IDX_W + 1;     // count that can hold the capacity
    localparam int MEM_DEPTH    = 1 << IDX_W;
    localparam int TIME_W       = 32;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(JOB_CAPACITY);

    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic              batch_end;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] job_id;
        logic             run_last;
        logic             overflow;
    } t_out_word;

endpackage

// ===== sv/fro_out_stage.sv =====
// fro_out_stage: output register holding one result word until the consumer takes it
// depends on fro_pkg for the result word type
module fro_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  fro_pkg::t_out_word i_word,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output fro_pkg::t_out_word o_word
);
    import fro_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_word r_word;

    // free when empty or when the held word leaves at this edge
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== sv/fcfs_rank_order_top.sv =====
// fcfs_rank_order_top: loads a batch of arrival times and emits job indices in run order
// depends on fro_pkg and fro_out_stage
//
// Jobs are loaded one word per cycle while the block is idle; each word holds an arrival
// time and a batch_end flag. Up to JOB_CAPACITY jobs are kept in an arrival memory; further
// jobs are dropped and every result of that batch then carries overflow. The word with
// batch_end starts ordering: for each job i the block reads its time, then streams all n
// stored times through the single read port of the arrival memory and counts the jobs that
// come first (earlier time, or equal time and loaded earlier), which gives a stable sort.
// The job index is written into an order memory at its rank. The order memory is then read
// out, with a read state and a load state per result word, the load waiting while the output
// register is not free, the last marked by run_last. No input word is taken from batch_end
// until the final result word sits in the output register.
module fcfs_rank_order_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fro_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fro_pkg::t_out_word o_out_word
);
    import fro_pkg::*;

    // one-hot sequencer
    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,  // loading jobs
        ST_RANK_TI   = 6'b000010,  // read time of job i
        ST_RANK_T0   = 6'b000100,  // capture time of job i, start streaming
        ST_RANK_SCAN = 6'b001000,  // compare streamed times, count rank
        ST_EMIT_RD   = 6'b010000,  // read order memory
        ST_EMIT_LD   = 6'b100000   // move order entry to output register
    } t_state;

    t_state r_state;
    t_state n_state;

    // memories
    logic [TIME_W-1:0] arrival_mem [MEM_DEPTH];
    logic [IDX_W-1:0]  order_mem   [MEM_DEPTH];
    logic [TIME_W-1:0] r_arr_rd;
    logic [IDX_W-1:0]  r_ord_rd;

    // batch bookkeeping
    logic [CNT_W-1:0] r_count;     // jobs loaded so far in this batch
    logic [CNT_W-1:0] n_count;
    logic             r_dropped;   // a job of this batch was dropped
    logic             n_dropped;
    logic [CNT_W-1:0] r_n;         // batch size being ordered
    logic [CNT_W-1:0] n_n;
    logic             r_ovf;       // overflow of batch being ordered
    logic             n_ovf;

    // ranking
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  n_i;
    logic [CNT_W-1:0]  r_j;        // next address to stream
    logic [CNT_W-1:0]  n_j;
    logic [IDX_W-1:0]  r_cmp_j;    // index of the time now on the read data
    logic [IDX_W-1:0]  n_cmp_j;
    logic              r_cmp_vld;
    logic              n_cmp_vld;
    logic [TIME_W-1:0] r_ti;
    logic [TIME_W-1:0] n_ti;
    logic [IDX_W-1:0]  r_rank;
    logic [IDX_W-1:0]  n_rank;
    logic [IDX_W-1:0]  rank_sum;
    logic              comes_first;
    logic              scan_done;

    // emit
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] n_k;
    logic             emit_last;

    // memory controls
    logic              arr_we;
    logic [IDX_W-1:0]  arr_waddr;
    logic              arr_re;
    logic [IDX_W-1:0]  arr_raddr;
    logic              ord_we;
    logic              ord_re;

    // output stage
    logic      out_load;
    logic      out_free;
    t_out_word out_word;

    logic in_acc;
    logic room;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign room       = (r_count < CAP_COUNT);

    // job j comes before job i on an earlier time, ties go to the earlier load
    assign comes_first = (r_arr_rd < r_ti) || ((r_arr_rd == r_ti) && (r_cmp_j < r_i));
    assign rank_sum    = r_rank + IDX_W'(comes_first);
    // last streamed time is on the read data when nothing more is issued
    assign scan_done   = r_cmp_vld && (r_j == r_n);
    assign emit_last   = ({1'b0, r_k} + CNT_W'(1)) == r_n;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_n       = r_n;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_cmp_j   = r_cmp_j;
        n_cmp_vld = r_cmp_vld;
        n_ti      = r_ti;
        n_rank    = r_rank;
        n_k       = r_k;
        arr_we    = 1'b0;
        arr_waddr = r_count[IDX_W-1:0];
        arr_re    = 1'b0;
        arr_raddr = r_i;
        ord_we    = 1'b0;
        ord_re    = 1'b0;
        out_load  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (room) begin
                        arr_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_word.batch_end) begin
                        n_n       = n_count;
                        n_ovf     = n_dropped;
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_i       = '0;
                        n_state   = ST_RANK_TI;
                    end
                end
            end
            ST_RANK_TI: begin
                arr_re    = 1'b1;
                arr_raddr = r_i;
                n_state   = ST_RANK_T0;
            end
            ST_RANK_T0: begin
                n_ti      = r_arr_rd;
                n_rank    = '0;
                arr_re    = 1'b1;
                arr_raddr = '0;
                n_cmp_j   = '0;
                n_cmp_vld = 1'b1;
                n_j       = CNT_W'(1);
                n_state   = ST_RANK_SCAN;
            end
            ST_RANK_SCAN: begin
                if (r_cmp_vld) begin
                    n_rank = rank_sum;
                end
                if (r_j != r_n) begin
                    arr_re    = 1'b1;
                    arr_raddr = r_j[IDX_W-1:0];
                    n_cmp_j   = r_j[IDX_W-1:0];
                    n_j       = r_j + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (scan_done) begin
                    ord_we = 1'b1;
                    if (({1'b0, r_i} + CNT_W'(1)) == r_n) begin
                        n_k     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = ST_RANK_TI;
                    end
                end
            end
            ST_EMIT_RD: begin
                ord_re  = 1'b1;
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // datapath registers, meaningful only in the states that load them
    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_ovf   <= n_ovf;
        r_i     <= n_i;
        r_j     <= n_j;
        r_cmp_j <= n_cmp_j;
        r_ti    <= n_ti;
        r_rank  <= n_rank;
        r_k     <= n_k;
    end

    // arrival memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (arr_we) begin
            arrival_mem[arr_waddr] <= i_in_word.arrival_time;
        end
        if (arr_re) begin
            r_arr_rd <= arrival_mem[arr_raddr];
        end
    end

    // order memory, job index written at its rank, read in run order
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            order_mem[rank_sum] <= r_i;
        end
        if (ord_re) begin
            r_ord_rd <= order_mem[r_k];
        end
    end

    always_comb begin
        out_word.job_id   = r_ord_rd;
        out_word.run_last = emit_last;
        out_word.overflow = r_ovf;
    end

    fro_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_word  (out_word),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule
